### rtl/core/led_blink_pattern_generator_macros.svh
// assertion macros for the led blink pattern generator
`ifndef LED_BLINK_PATTERN_GENERATOR_MACROS_SVH
`define LED_BLINK_PATTERN_GENERATOR_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define LBPG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define LBPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/lbpg_pkg.sv
// shared constants, types and helpers for the led blink pattern generator
`default_nettype none

package lbpg_pkg;

	localparam int GPIO_LEDS     = 3;
	localparam int EXPANDER_LEDS = 6;
	localparam int TOTAL_LEDS    = GPIO_LEDS + EXPANDER_LEDS;

	localparam int MODES_W   = 27;
	localparam int COLORS_W  = 12;
	localparam int CFG_W     = 27;
	localparam int ELAPSED_W = 10;
	localparam int GPIO_W    = 3;
	localparam int PORT_W    = 8;
	localparam int REM_W     = 16;
	localparam int PHASE_W   = 3;
	localparam int MODE_W    = 3;
	localparam int COLOR_W   = 2;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	localparam int MODES_EXT_W  = (MODE_W * TOTAL_LEDS > MODES_W) ?
		MODE_W * TOTAL_LEDS : MODES_W;
	localparam int COLORS_EXT_W = (COLOR_W * EXPANDER_LEDS > COLORS_W) ?
		COLOR_W * EXPANDER_LEDS : COLORS_W;

	localparam logic signed [REM_W-1:0] T_SHORT = 16'sd200;
	localparam logic signed [REM_W-1:0] T_LONG  = 16'sd1000;
	localparam logic signed [REM_W-1:0] T_FAST  = 16'sd50;

	localparam logic [PORT_W-1:0] PORT_RESET = 8'h3F;

	typedef enum logic [0:0] {
		REG_MODES  = 1'b0,
		REG_COLORS = 1'b1
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		PAT_DARK   = 3'd0,
		PAT_ONCE   = 3'd1,
		PAT_TWICE  = 3'd2,
		PAT_THRICE = 3'd3,
		PAT_BLINK  = 3'd4,
		PAT_FLASH  = 3'd5,
		PAT_LIT    = 3'd6
	} mode_t;

	typedef struct packed {
		logic en;
		logic lit;
	} drive_t;

	// saturate a one-bit-grown sum back to the counter width
	function automatic logic signed [REM_W-1:0] sat_rem(input logic signed [REM_W:0] v);
		logic signed [REM_W-1:0] r;
		if (v[REM_W] != v[REM_W-1]) begin
			r = v[REM_W] ? {1'b1, {(REM_W-1){1'b0}}} : {1'b0, {(REM_W-1){1'b1}}};
		end else begin
			r = v[REM_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/lbpg_led_seq.sv
// per-led phase sequencer with signed remaining-time counter
`default_nettype none

module lbpg_led_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            restart,
	input  lbpg_pkg::mode_t                 mode,
	input  logic [lbpg_pkg::ELAPSED_W-1:0]  elapsed,
	output lbpg_pkg::drive_t                drive
);
	import lbpg_pkg::*;

	logic [PHASE_W-1:0]      phase_q, phase_d, phase_inc, last;
	logic signed [REM_W-1:0] rem_q, rem_d, rem_sub, rem_add, on_t, final_t, reload;
	logic signed [REM_W:0]   diff, sum;
	logic                    run;

	always_comb begin
		on_t    = T_SHORT;
		final_t = T_LONG;
		last    = PHASE_W'(2);
		run     = 1'b1;
		drive   = '0;
		unique case (mode)
			PAT_DARK: begin
				run   = 1'b0;
				drive = '{en: 1'b1, lit: 1'b0};
			end
			PAT_ONCE: begin
				last = PHASE_W'(2);
			end
			PAT_TWICE: begin
				last = PHASE_W'(4);
			end
			PAT_THRICE: begin
				last = PHASE_W'(6);
			end
			PAT_BLINK: begin
				final_t = T_SHORT;
			end
			PAT_FLASH: begin
				on_t    = T_FAST;
				final_t = T_FAST;
			end
			PAT_LIT: begin
				run   = 1'b0;
				drive = '{en: 1'b1, lit: 1'b1};
			end
			default: begin
				run   = 1'b0;
				drive = '{en: 1'b1, lit: 1'b0};
			end
		endcase

		diff      = $signed({rem_q[REM_W-1], rem_q})
			- $signed({{(REM_W+1-ELAPSED_W){1'b0}}, elapsed});
		rem_sub   = sat_rem(diff);
		phase_inc = phase_q + PHASE_W'(1);
		reload    = (phase_inc == last) ? final_t : on_t;
		sum       = $signed({rem_sub[REM_W-1], rem_sub}) + $signed({reload[REM_W-1], reload});
		rem_add   = sat_rem(sum);

		phase_d = phase_q;
		rem_d   = rem_q;
		if (run) begin
			if (phase_q == '0) begin
				phase_d = PHASE_W'(1);
				rem_d   = on_t;
				drive   = '{en: 1'b1, lit: 1'b1};
			end else if (!rem_sub[REM_W-1] && (rem_sub != '0)) begin
				rem_d = rem_sub;
			end else if (phase_q >= last) begin
				phase_d = '0;
				rem_d   = rem_sub;
			end else begin
				phase_d = phase_inc;
				rem_d   = rem_add;
				drive   = '{en: 1'b1, lit: phase_inc[0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			rem_q   <= '0;
		end else if (restart) begin
			phase_q <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/led_blink_pattern_generator.sv
// data path: an accepted word is held in the input register, and its result goes through the result register to m_tdata
// throughput: one word per cycle while results are taken; all nine sequencers update in parallel in one pass
// the input register stalls only while the result register is full and not taken
// reset: config registers and led phases clear, gpio levels 0, port bytes 0x3F
// a config write restarts every led at phase 0 with a cleared counter
`default_nettype none
`include "led_blink_pattern_generator_macros.svh"

module led_blink_pattern_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lbpg_pkg::S_TDATA_W-1:0]  s_tdata,   // elapsed_ms[9:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lbpg_pkg::M_TDATA_W-1:0]  m_tdata,   // gpio_leds[2:0], port_a[10:3], port_b[18:11]
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [lbpg_pkg::CFG_W-1:0]      cfg_data
);
	import lbpg_pkg::*;

	logic                     valid_s1;
	logic [ELAPSED_W-1:0]     elapsed_s1;
	logic                     adv_s1;
	logic                     m_valid_q;
	logic [M_TDATA_W-1:0]     result_q;

	logic [MODES_W-1:0]       modes_q;
	logic [COLORS_W-1:0]      colors_q;
	logic [MODES_EXT_W-1:0]   modes_ext;
	logic [COLORS_EXT_W-1:0]  colors_ext;

	logic [GPIO_LEDS-1:0]     gpio_q, gpio_d;
	logic [PORT_W-1:0]        port_a_q, port_a_d, port_b_q, port_b_d;
	logic [COLOR_W-1:0]       col;
	drive_t                   drives [TOTAL_LEDS];

	assign adv_s1   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = result_q;

	assign modes_ext  = MODES_EXT_W'(modes_q);
	assign colors_ext = COLORS_EXT_W'(colors_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q  <= '0;
			colors_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODES:  modes_q  <= cfg_data[MODES_W-1:0];
				REG_COLORS: colors_q <= cfg_data[COLORS_W-1:0];
				default:    modes_q  <= modes_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			elapsed_s1 <= s_tdata[ELAPSED_W-1:0];
		end
	end

	for (genvar i = 0; i < TOTAL_LEDS; i++) begin : g_led
		lbpg_led_seq u_seq (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (adv_s1),
			.restart (cfg_we),
			.mode    (mode_t'(modes_ext[MODE_W*i +: MODE_W])),
			.elapsed (elapsed_s1),
			.drive   (drives[i])
		);
	end

	// next led levels
	always_comb begin
		gpio_d   = gpio_q;
		port_a_d = port_a_q;
		port_b_d = port_b_q;
		col      = '0;
		for (int i = 0; i < GPIO_LEDS; i++) begin
			if (drives[i].en) begin
				gpio_d[i] = drives[i].lit;
			end
		end
		for (int j = 0; j < EXPANDER_LEDS; j++) begin
			col = colors_ext[COLOR_W*j +: COLOR_W];
			if (drives[GPIO_LEDS+j].en) begin
				port_a_d[j] = !drives[GPIO_LEDS+j].lit || col[0];
				port_b_d[j] = !drives[GPIO_LEDS+j].lit || col[1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpio_q   <= '0;
			port_a_q <= PORT_RESET;
			port_b_q <= PORT_RESET;
		end else if (adv_s1) begin
			gpio_q   <= gpio_d;
			port_a_q <= port_a_d;
			port_b_q <= port_b_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= M_TDATA_W'({port_b_d, port_a_d, GPIO_W'(gpio_d)});
		end
	end

	`LBPG_ASSERT_NOW(a_stall_blocks_input, valid_s1 && m_tvalid && !m_tready, !s_tready, "input taken while result stalled")
	`LBPG_ASSERT_NEXT(a_adv_gives_result, adv_s1, m_tvalid, "advanced word gave no result")
	`LBPG_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, valid_s1, "accepted word lost")

endmodule

`default_nettype wire
